[rtl/assert_macros.svh]
// Assertion macros used by the checker file of the color converter.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside of reset.
`define ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check a property on every rising clock edge, reset included.
`define ASSERT_CLK_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[rtl/hsvrgb_pkg.sv]
// Shared types and constants of the hue to RGB888 converter.
package hsvrgb_pkg;

   localparam int HUE_W         = 16;
   localparam int CFG_W         = 9;
   localparam int CH_W          = 8;
   localparam int RSP_TDATA_W   = 48;
   localparam int NUM_STAGES    = 7;

   localparam int HUE_FULL_TURN = 23040;
   localparam int HUE_SECTOR    = 3840;

   localparam logic [CFG_W-1:0] Q8_ONE = 9'd256;

   typedef enum logic [2:0] {
      SECTOR_0 = 3'd0,
      SECTOR_1 = 3'd1,
      SECTOR_2 = 3'd2,
      SECTOR_3 = 3'd3,
      SECTOR_4 = 3'd4,
      SECTOR_5 = 3'd5
   } sector_type;

   typedef enum logic {
      CSR_SATURATION = 1'b0,
      CSR_BRIGHTNESS = 1'b1
   } csr_addr_type;

endpackage

[rtl/hsv_to_rgb888_core.sv]
// Pipeline from an accepted hue transaction to its color on rsp_tvalid: seven pipeline
// stages, each with a valid bit; one transaction per cycle unless a stalled output backs it up.
// A stalled output holds its stage; empty stages upstream still fill, so req_tready
// stays high while any stage is empty.
// Reset clears all valid bits and sets saturation and brightness to 256 (1.0).
module hsv_to_rgb888_core #(
   parameter int FRACTION_BITS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // [15:0] hue
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata,   // [7:0] red, [15:8] green, [23:16] blue, [47:24] packed_color
   input  logic        csr_we,
   input  logic        csr_addr,
   input  logic [8:0]  csr_wdata
);

   localparam int FB     = FRACTION_BITS;
   localparam int NS     = hsvrgb_pkg::NUM_STAGES;
   localparam int CW     = hsvrgb_pkg::CFG_W;
   localparam int XW     = FB + 4;
   localparam int PW     = 2 * XW + 1;
   localparam int AW     = FB + 9;
   localparam int VW     = FB + 17;
   localparam int CH_LSB = FB + 16;
   localparam logic [63:0] RECIP_FULL = ((64'd1 << (XW + 4)) / 15) + 64'd1;
   localparam logic [XW:0] RECIP      = RECIP_FULL[XW:0];

   localparam logic signed [17:0] TURN_S  = 18'(hsvrgb_pkg::HUE_FULL_TURN);
   localparam logic signed [17:0] TURN2_S = 18'(2 * hsvrgb_pkg::HUE_FULL_TURN);
   localparam logic [14:0] SEC1 = 15'(1 * hsvrgb_pkg::HUE_SECTOR);
   localparam logic [14:0] SEC2 = 15'(2 * hsvrgb_pkg::HUE_SECTOR);
   localparam logic [14:0] SEC3 = 15'(3 * hsvrgb_pkg::HUE_SECTOR);
   localparam logic [14:0] SEC4 = 15'(4 * hsvrgb_pkg::HUE_SECTOR);
   localparam logic [14:0] SEC5 = 15'(5 * hsvrgb_pkg::HUE_SECTOR);

   logic [CW-1:0] sat_ff, sat_in, bri_ff, bri_in;
   logic [CW-1:0] wdata_clamped;

   logic [NS-1:0] vld_ff, vld_in, adv;

   logic signed [17:0] hue_ext;
   logic signed [17:0] wrap_full;
   logic [14:0] wrap_ff, wrap_in;

   hsvrgb_pkg::sector_type sec2_ff, sec2_in, sec3_ff, sec4_ff;
   logic [14:0] rem_full;
   logic [11:0] rem_ff, rem_in;

   logic [XW-1:0] xdiv;
   logic [PW-1:0] prod_ff, prod_in;

   logic [FB-1:0] frac;
   logic [FB:0]   one_minus_f;
   logic [CW+FB-1:0] sf_full;
   logic [CW+FB:0]   sfc_full;
   logic [AW-1:0] sf_ff, sf_in, sfc_ff, sfc_in;

   logic [AW-1:0] a_v, a_p, a_q, a_t;
   logic [AW-1:0] ar_ff, ar_in, ag_ff, ag_in, ab_ff, ab_in;

   logic [CW+AW-1:0] xr_full, xg_full, xb_full;
   logic [VW-1:0] xr_ff, xg_ff, xb_ff;

   logic [VW+7:0] yr, yg, yb;
   logic [7:0] red_ff, red_in, green_ff, green_in, blue_ff, blue_in;

   // configuration
   always_comb begin
      wdata_clamped = (csr_wdata > hsvrgb_pkg::Q8_ONE) ? hsvrgb_pkg::Q8_ONE : csr_wdata;
      sat_in = sat_ff;
      bri_in = bri_ff;
      if (csr_we) begin
         unique case (hsvrgb_pkg::csr_addr_type'(csr_addr))
            hsvrgb_pkg::CSR_SATURATION: sat_in = wdata_clamped;
            hsvrgb_pkg::CSR_BRIGHTNESS: bri_in = wdata_clamped;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sat_ff <= hsvrgb_pkg::Q8_ONE;
         bri_ff <= hsvrgb_pkg::Q8_ONE;
      end else begin
         sat_ff <= sat_in;
         bri_ff <= bri_in;
      end
   end

   // stage handshake
   always_comb begin
      adv[NS-1] = ~vld_ff[NS-1] | rsp_tready;
      for (int i = NS - 2; i >= 0; i--) begin
         adv[i] = ~vld_ff[i] | adv[i+1];
      end
      vld_in[0] = adv[0] ? req_tvalid : vld_ff[0];
      for (int i = 1; i < NS; i++) begin
         vld_in[i] = adv[i] ? vld_ff[i-1] : vld_ff[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   assign req_tready = adv[0];
   assign rsp_tvalid = vld_ff[NS-1];

   // stage 1: wrap hue into one turn
   always_comb begin
      hue_ext = 18'(signed'(req_tdata));
      if (hue_ext >= TURN_S) begin
         wrap_full = hue_ext - TURN_S;
      end else if (hue_ext >= 18'sd0) begin
         wrap_full = hue_ext;
      end else if (hue_ext >= -TURN_S) begin
         wrap_full = hue_ext + TURN_S;
      end else begin
         wrap_full = hue_ext + TURN2_S;
      end
      wrap_in = wrap_full[14:0];
   end

   // stage 2: sector and remainder
   always_comb begin
      priority if (wrap_ff >= SEC5) begin
         sec2_in  = hsvrgb_pkg::SECTOR_5;
         rem_full = wrap_ff - SEC5;
      end else if (wrap_ff >= SEC4) begin
         sec2_in  = hsvrgb_pkg::SECTOR_4;
         rem_full = wrap_ff - SEC4;
      end else if (wrap_ff >= SEC3) begin
         sec2_in  = hsvrgb_pkg::SECTOR_3;
         rem_full = wrap_ff - SEC3;
      end else if (wrap_ff >= SEC2) begin
         sec2_in  = hsvrgb_pkg::SECTOR_2;
         rem_full = wrap_ff - SEC2;
      end else if (wrap_ff >= SEC1) begin
         sec2_in  = hsvrgb_pkg::SECTOR_1;
         rem_full = wrap_ff - SEC1;
      end else begin
         sec2_in  = hsvrgb_pkg::SECTOR_0;
         rem_full = wrap_ff;
      end
      rem_in = rem_full[11:0];
   end

   // stage 3: fraction by reciprocal multiply (divide by 15 after scaling)
   always_comb begin
      xdiv    = XW'(rem_ff) << (FB - 8);
      prod_in = xdiv * RECIP;
   end

   // stage 4: saturation times fraction and its complement
   always_comb begin
      frac        = prod_ff[XW+FB+3:XW+4];
      one_minus_f = (FB + 1)'(1) << FB;
      one_minus_f = one_minus_f - (FB + 1)'(frac);
      sf_full     = sat_ff * frac;
      sfc_full    = sat_ff * one_minus_f;
      sf_in       = sf_full[AW-1:0];
      sfc_in      = sfc_full[AW-1:0];
   end

   // stage 5: form v, p, q, t and route by sector
   always_comb begin
      a_v = AW'(1) << (FB + 8);
      a_p = AW'(hsvrgb_pkg::Q8_ONE - sat_ff) << FB;
      a_q = a_v - sf_ff;
      a_t = a_v - sfc_ff;
      unique case (sec4_ff)
         hsvrgb_pkg::SECTOR_0: begin ar_in = a_v; ag_in = a_t; ab_in = a_p; end
         hsvrgb_pkg::SECTOR_1: begin ar_in = a_q; ag_in = a_v; ab_in = a_p; end
         hsvrgb_pkg::SECTOR_2: begin ar_in = a_p; ag_in = a_v; ab_in = a_t; end
         hsvrgb_pkg::SECTOR_3: begin ar_in = a_p; ag_in = a_q; ab_in = a_v; end
         hsvrgb_pkg::SECTOR_4: begin ar_in = a_t; ag_in = a_p; ab_in = a_v; end
         default:              begin ar_in = a_v; ag_in = a_p; ab_in = a_q; end
      endcase
   end

   // stage 6: scale by brightness
   always_comb begin
      xr_full = bri_ff * ar_ff;
      xg_full = bri_ff * ag_ff;
      xb_full = bri_ff * ab_ff;
   end

   // stage 7: times 255, truncate to 8 bits
   always_comb begin
      yr       = {xr_ff, 8'd0} - (VW + 8)'(xr_ff);
      yg       = {xg_ff, 8'd0} - (VW + 8)'(xg_ff);
      yb       = {xb_ff, 8'd0} - (VW + 8)'(xb_ff);
      red_in   = yr[CH_LSB+7:CH_LSB];
      green_in = yg[CH_LSB+7:CH_LSB];
      blue_in  = yb[CH_LSB+7:CH_LSB];
   end

   always_ff @(posedge clock) begin
      if (adv[0]) begin
         wrap_ff <= wrap_in;
      end
      if (adv[1]) begin
         sec2_ff <= sec2_in;
         rem_ff  <= rem_in;
      end
      if (adv[2]) begin
         sec3_ff <= sec2_ff;
         prod_ff <= prod_in;
      end
      if (adv[3]) begin
         sec4_ff <= sec3_ff;
         sf_ff   <= sf_in;
         sfc_ff  <= sfc_in;
      end
      if (adv[4]) begin
         ar_ff <= ar_in;
         ag_ff <= ag_in;
         ab_ff <= ab_in;
      end
      if (adv[5]) begin
         xr_ff <= xr_full[VW-1:0];
         xg_ff <= xg_full[VW-1:0];
         xb_ff <= xb_full[VW-1:0];
      end
      if (adv[6]) begin
         red_ff   <= red_in;
         green_ff <= green_in;
         blue_ff  <= blue_in;
      end
   end

   assign rsp_tdata = {red_ff, green_ff, blue_ff, blue_ff, green_ff, red_ff};

endmodule

[rtl/hsvrgb_checker.sv]
// Port-level checker of the hue to RGB888 converter and its bind.
`include "assert_macros.svh"

module hsvrgb_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [47:0] rsp_tdata
);

   localparam int CH = hsvrgb_pkg::CH_W;

   logic [CH-1:0]   red, green, blue;
   logic [3*CH-1:0] packed_color;
   logic            packed_ok;
   logic            rsp_stall;

   assign red          = rsp_tdata[CH-1:0];
   assign green        = rsp_tdata[2*CH-1:CH];
   assign blue         = rsp_tdata[3*CH-1:2*CH];
   assign packed_color = rsp_tdata[hsvrgb_pkg::RSP_TDATA_W-1:3*CH];
   assign packed_ok    = (packed_color == {red, green, blue});
   assign rsp_stall    = rsp_tvalid && !rsp_tready;

   `ASSERT_CLK_ALWAYS(a_reset_empties, clock, reset |=> !rsp_tvalid, "valid result after reset")
   `ASSERT_CLK(a_packed_match, clock, reset, rsp_tvalid |-> packed_ok, "packed color mismatch")
   `ASSERT_CLK(a_empty_ready, clock, reset, !rsp_tvalid |-> req_tready, "input stalled when empty")
   `ASSERT_CLK(a_rsp_hold, clock, reset, rsp_stall |=> rsp_tvalid && $stable(rsp_tdata), "held data moved")

endmodule

bind hsv_to_rgb888_core hsvrgb_checker u_hsvrgb_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

[tb/sv/hsv_to_rgb888_core_tb.sv]
// Self-checking testbench for the hue to RGB888 converter core.
`timescale 1ns / 100ps

module hsv_to_rgb888_core_tb;

   localparam int FRAC_BITS   = 16;
   localparam int DRAIN_LIMIT = 2000;

   typedef struct {
      logic signed [hsvrgb_pkg::HUE_W-1:0] hue;
      logic [hsvrgb_pkg::CH_W-1:0]         red;
      logic [hsvrgb_pkg::CH_W-1:0]         green;
      logic [hsvrgb_pkg::CH_W-1:0]         blue;
      logic [23:0]                         packed_color;
   } color_type;

   logic                               clock;
   logic                               reset;
   logic                               req_tvalid;
   logic                               req_tready;
   logic [15:0]                        req_tdata;
   logic                               rsp_tvalid;
   logic                               rsp_tready;
   logic [hsvrgb_pkg::RSP_TDATA_W-1:0] rsp_tdata;
   logic                               csr_we;
   hsvrgb_pkg::csr_addr_type           csr_addr;
   logic [hsvrgb_pkg::CFG_W-1:0]       csr_wdata;

   logic [hsvrgb_pkg::CFG_W-1:0] model_saturation;
   logic [hsvrgb_pkg::CFG_W-1:0] model_brightness;
   color_type                    pending_colors[$];
   int                           error_count;
   int                           rsp_hold;
   bit                           req_idle_on;
   bit                           rsp_idle_on;

   hsv_to_rgb888_core #(.FRACTION_BITS(FRAC_BITS)) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   always #2 clock = ~clock;

   function automatic logic [hsvrgb_pkg::CFG_W-1:0] clamp_unit(
         logic [hsvrgb_pkg::CFG_W-1:0] raw);
      return (raw > hsvrgb_pkg::Q8_ONE) ? hsvrgb_pkg::Q8_ONE : raw;
   endfunction

   function automatic logic [hsvrgb_pkg::CH_W-1:0] scale_channel(longint unsigned x);
      longint unsigned y;
      y = (x * 64'd255) >> (16 + FRAC_BITS);
      return y[hsvrgb_pkg::CH_W-1:0];
   endfunction

   function automatic color_type hue_to_color(logic signed [hsvrgb_pkg::HUE_W-1:0] hue);
      color_type              c;
      int                     wrapped;
      int unsigned            rem;
      hsvrgb_pkg::sector_type sector;
      longint unsigned        one, f, s, v, vv, pv, qv, tv, r, g, b;
      wrapped = int'(hue) % hsvrgb_pkg::HUE_FULL_TURN;
      if (wrapped < 0) wrapped += hsvrgb_pkg::HUE_FULL_TURN;
      sector = hsvrgb_pkg::sector_type'(wrapped / hsvrgb_pkg::HUE_SECTOR);
      rem    = wrapped % hsvrgb_pkg::HUE_SECTOR;
      one    = 64'd1 << FRAC_BITS;
      f      = (longint'(rem) << FRAC_BITS) / hsvrgb_pkg::HUE_SECTOR;
      s      = longint'(model_saturation);
      v      = longint'(model_brightness);
      vv     = v * 256 * one;
      pv     = v * (256 - s) * one;
      qv     = v * (256 * one - s * f);
      tv     = v * (256 * one - s * (one - f));
      case (sector)
         hsvrgb_pkg::SECTOR_0: begin r = vv; g = tv; b = pv; end
         hsvrgb_pkg::SECTOR_1: begin r = qv; g = vv; b = pv; end
         hsvrgb_pkg::SECTOR_2: begin r = pv; g = vv; b = tv; end
         hsvrgb_pkg::SECTOR_3: begin r = pv; g = qv; b = vv; end
         hsvrgb_pkg::SECTOR_4: begin r = tv; g = pv; b = vv; end
         default: begin r = vv; g = pv; b = qv; end
      endcase
      c.hue          = hue;
      c.red          = scale_channel(r);
      c.green        = scale_channel(g);
      c.blue         = scale_channel(b);
      c.packed_color = {c.red, c.green, c.blue};
      return c;
   endfunction

   task automatic report_mismatch(input string msg);
      $display("MISMATCH at %0t: %s", $realtime, msg);
      error_count++;
   endtask

   // Response side: sample at the rising edge, compare against the oldest prediction.
   always @(posedge clock) begin
      color_type want;
      logic [hsvrgb_pkg::CH_W-1:0] got_red, got_green, got_blue;
      logic [23:0] got_packed;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got_red    = rsp_tdata[7:0];
         got_green  = rsp_tdata[15:8];
         got_blue   = rsp_tdata[23:16];
         got_packed = rsp_tdata[47:24];
         if (pending_colors.size() == 0) begin
            report_mismatch($sformatf("unexpected transaction, data %h", rsp_tdata));
         end else begin
            want = pending_colors.pop_front();
            if (got_red !== want.red)
               report_mismatch($sformatf("hue %0d red %0d, want %0d",
                                         want.hue, got_red, want.red));
            if (got_green !== want.green)
               report_mismatch($sformatf("hue %0d green %0d, want %0d",
                                         want.hue, got_green, want.green));
            if (got_blue !== want.blue)
               report_mismatch($sformatf("hue %0d blue %0d, want %0d",
                                         want.hue, got_blue, want.blue));
            if (got_packed !== want.packed_color)
               report_mismatch($sformatf("hue %0d packed %h, want %h",
                                         want.hue, got_packed, want.packed_color));
         end
         rsp_hold = rsp_idle_on ? $urandom_range(0, 15) : 0;
      end
   end

   // Hold rsp_tready low while the randomly drawn hold count runs down.
   always @(negedge clock) begin
      if (rsp_hold > 0) begin
         rsp_tready <= 1'b0;
         rsp_hold = rsp_hold - 1;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // Called at a falling edge; returns at a falling edge.
   task automatic send_hue(input logic signed [hsvrgb_pkg::HUE_W-1:0] hue);
      int gap;
      gap = req_idle_on ? $urandom_range(0, 15) : 0;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= hue;
      do @(posedge clock); while (!req_tready);
      pending_colors.push_back(hue_to_color(hue));
      @(negedge clock);
   endtask

   task automatic wait_drained();
      int cycles;
      req_tvalid <= 1'b0;
      cycles = 0;
      while (pending_colors.size() != 0 && cycles < DRAIN_LIMIT) begin
         @(negedge clock);
         cycles++;
      end
      if (pending_colors.size() != 0)
         report_mismatch($sformatf("%0d transactions never returned",
                                   pending_colors.size()));
      pending_colors.delete();
      repeat (hsvrgb_pkg::NUM_STAGES + 3) @(negedge clock);
   endtask

   task automatic write_config(input logic [hsvrgb_pkg::CFG_W-1:0] sat,
                               input logic [hsvrgb_pkg::CFG_W-1:0] bri);
      wait_drained();
      csr_we    <= 1'b1;
      csr_addr  <= hsvrgb_pkg::CSR_SATURATION;
      csr_wdata <= sat;
      @(negedge clock);
      model_saturation = clamp_unit(sat);
      csr_addr  <= hsvrgb_pkg::CSR_BRIGHTNESS;
      csr_wdata <= bri;
      @(negedge clock);
      model_brightness = clamp_unit(bri);
      csr_we    <= 1'b0;
      @(negedge clock);
   endtask

   task automatic test_directed_hues();
      logic signed [hsvrgb_pkg::HUE_W-1:0] hues[$];
      hues = '{-16'sd32768, 16'sd32767, 16'sd0, -16'sd1, 16'sd1, 16'sd3839, 16'sd3840,
               16'sd7680, 16'sd11520, 16'sd15360, 16'sd19200, 16'sd23039, 16'sd23040,
               -16'sd23040, -16'sd23041, 16'sd1920, -16'sd3840, 16'sd25000};
      req_idle_on = 0;
      rsp_idle_on = 0;
      foreach (hues[i]) send_hue(hues[i]);
   endtask

   task automatic test_register_clamp();
      req_idle_on = 1;
      rsp_idle_on = 1;
      write_config(9'd511, 9'd300);
      for (int k = 0; k < 6; k++) send_hue(16'(k * hsvrgb_pkg::HUE_SECTOR + 1000));
   endtask

   task automatic test_random_settings();
      logic [hsvrgb_pkg::CFG_W-1:0] sat_list[$];
      logic [hsvrgb_pkg::CFG_W-1:0] bri_list[$];
      logic signed [hsvrgb_pkg::HUE_W-1:0] hue;
      sat_list = '{9'd0, 9'd256, 9'd0, 9'd256, 9'd1, 9'd255};
      bri_list = '{9'd0, 9'd256, 9'd256, 9'd0, 9'd255, 9'd1};
      for (int k = 0; k < 4; k++) begin
         sat_list.push_back(9'($urandom_range(0, 511)));
         bri_list.push_back(9'($urandom_range(0, 511)));
      end
      foreach (sat_list[i]) begin
         write_config(sat_list[i], bri_list[i]);
         req_idle_on = (i % 4) != 1;
         rsp_idle_on = (i % 4) != 2;
         for (int n = 0; n < 155; n++) begin
            if ($urandom_range(0, 3) == 0)
               hue = 16'((int'($urandom_range(0, 16)) - 8) * hsvrgb_pkg::HUE_SECTOR
                         + int'($urandom_range(0, 2)) - 1);
            else
               hue = 16'($urandom);
            send_hue(hue);
         end
      end
   endtask

   initial begin
      clock            = 1'b0;
      reset            = 1'b1;
      req_tvalid       = 1'b0;
      req_tdata        = '0;
      rsp_tready       = 1'b0;
      csr_we           = 1'b0;
      csr_addr         = hsvrgb_pkg::CSR_SATURATION;
      csr_wdata        = '0;
      rsp_hold         = 0;
      error_count      = 0;
      req_idle_on      = 0;
      rsp_idle_on      = 0;
      model_saturation = hsvrgb_pkg::Q8_ONE;
      model_brightness = hsvrgb_pkg::Q8_ONE;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_directed_hues();
      test_register_clamp();
      test_random_settings();
      wait_drained();

      if (error_count == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

   initial begin
      #2_000_000;
      $display("Some tests failed");
      $finish;
   end

endmodule
